[rtl/lotsch_pkg.sv]
// Shared types and constants of the lottery scheduler.
// Holds the microcode word, the status flags and the control program table.
// No dependencies.
package lotsch_pkg;

  // Width of the random value and the last step of the remainder loop
  localparam int unsigned RND_W = 31;
  localparam logic [4:0] MOD_LAST = 5'(RND_W - 1);

  // Widths fixed by the transaction fields
  localparam int unsigned TIX_W  = 8;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned WIN_W  = 5;
  localparam int unsigned SLOT_W = 16;

  // Program counter and step addresses
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_IDLE     = 4'd0;
  localparam pc_t ST_SUM_CLR  = 4'd1;
  localparam pc_t ST_SUM      = 4'd2;
  localparam pc_t ST_ZCHK     = 4'd3;
  localparam pc_t ST_MOD      = 4'd4;
  localparam pc_t ST_WALK_CLR = 4'd5;
  localparam pc_t ST_WALK     = 4'd6;
  localparam pc_t ST_GRANT    = 4'd7;
  localparam pc_t ST_EMPTY    = 4'd8;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    DP_NOP      = 3'd0,
    DP_SUM_CLR  = 3'd1,
    DP_SUM      = 3'd2,
    DP_MOD_INIT = 3'd3,
    DP_MOD      = 3'd4,
    DP_WALK_CLR = 3'd5,
    DP_WALK     = 3'd6,
    DP_GRANT    = 3'd7
  } dp_op_e;

  // Jump condition; when true the target is taken, else the next step
  typedef enum logic [2:0] {
    CD_ALWAYS     = 3'd0,
    CD_NO_DRAW    = 3'd1,
    CD_SCAN_BUSY  = 3'd2,
    CD_TOTAL_ZERO = 3'd3,
    CD_MOD_BUSY   = 3'd4,
    CD_WALK_BUSY  = 3'd5,
    CD_NEVER      = 3'd6
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    logic   empty;   // report a zero ticket total on DP_GRANT
    cond_e  cond;
    pc_t    target;
  } uc_word_t;

  typedef struct packed {
    logic draw_req;
    logic scan_busy;
    logic total_zero;
    logic mod_busy;
    logic walk_busy;
  } dp_status_t;

  // Control program
  function automatic uc_word_t uc_rom(input pc_t pc);
    uc_word_t w;
    case (pc)
      ST_IDLE:     w = '{op: DP_NOP,      empty: 1'b0, cond: CD_NO_DRAW,    target: ST_IDLE};
      ST_SUM_CLR:  w = '{op: DP_SUM_CLR,  empty: 1'b0, cond: CD_NEVER,      target: ST_IDLE};
      ST_SUM:      w = '{op: DP_SUM,      empty: 1'b0, cond: CD_SCAN_BUSY,  target: ST_SUM};
      ST_ZCHK:     w = '{op: DP_MOD_INIT, empty: 1'b0, cond: CD_TOTAL_ZERO, target: ST_EMPTY};
      ST_MOD:      w = '{op: DP_MOD,      empty: 1'b0, cond: CD_MOD_BUSY,   target: ST_MOD};
      ST_WALK_CLR: w = '{op: DP_WALK_CLR, empty: 1'b0, cond: CD_NEVER,      target: ST_IDLE};
      ST_WALK:     w = '{op: DP_WALK,     empty: 1'b0, cond: CD_WALK_BUSY,  target: ST_WALK};
      ST_GRANT:    w = '{op: DP_GRANT,    empty: 1'b0, cond: CD_ALWAYS,     target: ST_IDLE};
      ST_EMPTY:    w = '{op: DP_GRANT,    empty: 1'b1, cond: CD_ALWAYS,     target: ST_IDLE};
      default:     w = '{op: DP_NOP,      empty: 1'b0, cond: CD_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/lotsch_seq.sv]
// Microcode sequencer of the lottery scheduler: step counter and program table.
// Depends on lotsch_pkg.
module lotsch_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lotsch_pkg::dp_status_t status_i,
  output lotsch_pkg::uc_word_t   word_o,
  output logic                  busy_o
);

  lotsch_pkg::pc_t      pc_q, pc_d;
  lotsch_pkg::uc_word_t word;
  logic                 take;

  // Fetch the control word of the current step
  assign word = lotsch_pkg::uc_rom(pc_q);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      lotsch_pkg::CD_ALWAYS:     take = 1'b1;
      lotsch_pkg::CD_NO_DRAW:    take = ~status_i.draw_req;
      lotsch_pkg::CD_SCAN_BUSY:  take = status_i.scan_busy;
      lotsch_pkg::CD_TOTAL_ZERO: take = status_i.total_zero;
      lotsch_pkg::CD_MOD_BUSY:   take = status_i.mod_busy;
      lotsch_pkg::CD_WALK_BUSY:  take = status_i.walk_busy;
      lotsch_pkg::CD_NEVER:      take = 1'b0;
      default:                   take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + lotsch_pkg::pc_t'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= lotsch_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign word_o = word;
  assign busy_o = (pc_q != lotsch_pkg::ST_IDLE);

endmodule

[rtl/lotsch_dp.sv]
// Datapath of the lottery scheduler: ticket table, ticket sum, bit-serial
// remainder, cumulative walk, slot counter and result registers.
// Depends on lotsch_pkg.
module lotsch_dp #(
  parameter int unsigned MAX_TASK_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lotsch_pkg::uc_word_t             word_i,
  input  logic                             accept_i,
  input  logic                             op_i,
  input  logic [lotsch_pkg::IDX_W-1:0]     task_index_i,
  input  logic [lotsch_pkg::TIX_W-1:0]     ticket_count_i,
  input  logic [lotsch_pkg::RND_W-1:0]     random_value_i,
  input  logic [lotsch_pkg::CNT_W-1:0]     task_count_i,
  output lotsch_pkg::dp_status_t           status_o,
  output logic                             done_o,
  output logic [lotsch_pkg::WIN_W-1:0]     winner_id_o,
  output logic [lotsch_pkg::SLOT_W-1:0]    slot_start_o,
  output logic                             no_tickets_o
);

  localparam int unsigned AW = (MAX_TASK_COUNT > 1) ? $clog2(MAX_TASK_COUNT) : 1;
  localparam int unsigned CW = $clog2(MAX_TASK_COUNT + 1);
  localparam int unsigned TW = $clog2(MAX_TASK_COUNT * 255 + 1);

  // Ticket table with per-entry valid bits
  logic [lotsch_pkg::TIX_W-1:0] tbl_mem [MAX_TASK_COUNT];
  logic [MAX_TASK_COUNT-1:0]    ent_vld_q;
  logic [lotsch_pkg::TIX_W-1:0] rd_data_q;
  logic                         rd_ent_vld_q;
  logic [lotsch_pkg::TIX_W-1:0] rd_tix;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;

  // Scan control
  logic [CW-1:0]                idx_q, idx_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [AW-1:0]                rd_idx_q;
  logic [CW-1:0]                active;
  logic                         issue;
  logic                         scan_done;

  // Arithmetic
  logic [TW-1:0]                total_q, total_d;
  logic [TW-1:0]                rem_q, rem_d;
  logic [TW-1:0]                run_q, run_d;
  logic [TW-1:0]                run_sum;
  logic [TW:0]                  trial;
  logic [lotsch_pkg::RND_W-1:0] rnd_q, rnd_d;
  logic [4:0]                   mcnt_q, mcnt_d;
  logic                         hit;
  logic [lotsch_pkg::WIN_W-1:0] win_q, win_d;

  // Slot counter and result registers
  logic [lotsch_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic                          done_q;
  logic [lotsch_pkg::WIN_W-1:0]  res_win_q;
  logic [lotsch_pkg::SLOT_W-1:0] res_slot_q;
  logic                          res_empty_q;

  // Saturate the active task count at the table size
  assign active = (32'(task_count_i) > MAX_TASK_COUNT) ? CW'(MAX_TASK_COUNT)
                                                       : CW'(task_count_i);

  // Table write on a load transaction that addresses an existing entry
  assign wr_en   = accept_i && !op_i && (32'(task_index_i) < MAX_TASK_COUNT);
  assign wr_addr = AW'(task_index_i);
  assign rd_addr = idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= ticket_count_i;
    end
    rd_data_q <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      rd_ent_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      rd_ent_vld_q <= ent_vld_q[rd_addr];
    end
  end

  // An entry never written reads as zero tickets
  assign rd_tix = rd_ent_vld_q ? rd_data_q : '0;

  assign issue     = (idx_q < active);
  assign scan_done = !issue && !rd_vld_q;
  assign run_sum   = run_q + TW'(rd_tix);
  assign hit       = rd_vld_q && (rem_q < run_sum);
  assign trial     = {rem_q, rnd_q[lotsch_pkg::RND_W-1]};

  // Datapath operations selected by the control word
  always_comb begin
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    total_d  = total_q;
    rem_d    = rem_q;
    run_d    = run_q;
    rnd_d    = rnd_q;
    mcnt_d   = mcnt_q;
    win_d    = win_q;
    slot_d   = slot_q;
    if (accept_i) begin
      rnd_d = random_value_i;
    end
    case (word_i.op)
      lotsch_pkg::DP_SUM_CLR: begin
        idx_d   = '0;
        total_d = '0;
      end
      lotsch_pkg::DP_SUM: begin
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (rd_vld_q) begin
          total_d = total_q + TW'(rd_tix);
        end
      end
      lotsch_pkg::DP_MOD_INIT: begin
        rem_d  = '0;
        mcnt_d = '0;
      end
      lotsch_pkg::DP_MOD: begin
        // one restoring step of the remainder per cycle
        if (trial >= {1'b0, total_q}) begin
          rem_d = TW'(trial - {1'b0, total_q});
        end else begin
          rem_d = trial[TW-1:0];
        end
        rnd_d  = rnd_q << 1;
        mcnt_d = mcnt_q + 5'd1;
      end
      lotsch_pkg::DP_WALK_CLR: begin
        idx_d = '0;
        run_d = '0;
        win_d = '0;
      end
      lotsch_pkg::DP_WALK: begin
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (rd_vld_q) begin
          run_d = run_sum;
        end
        if (hit) begin
          win_d = lotsch_pkg::WIN_W'({1'b0, rd_idx_q} + (AW + 1)'(1));
        end
      end
      lotsch_pkg::DP_GRANT: begin
        if (!word_i.empty) begin
          slot_d = slot_q + lotsch_pkg::SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Hold control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      mcnt_q   <= '0;
      slot_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      mcnt_q   <= mcnt_d;
      slot_q   <= slot_d;
      done_q   <= (word_i.op == lotsch_pkg::DP_GRANT);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    total_q  <= total_d;
    rem_q    <= rem_d;
    run_q    <= run_d;
    rnd_q    <= rnd_d;
    win_q    <= win_d;
    if (word_i.op == lotsch_pkg::DP_GRANT) begin
      res_win_q   <= word_i.empty ? '0 : win_q;
      res_slot_q  <= word_i.empty ? '0 : slot_q;
      res_empty_q <= word_i.empty;
    end
  end

  assign status_o.draw_req   = accept_i && op_i;
  assign status_o.scan_busy  = !scan_done;
  assign status_o.total_zero = (total_q == '0);
  assign status_o.mod_busy   = (mcnt_q != lotsch_pkg::MOD_LAST);
  assign status_o.walk_busy  = !hit && !scan_done;

  assign done_o       = done_q;
  assign winner_id_o  = res_win_q;
  assign slot_start_o = res_slot_q;
  assign no_tickets_o = res_empty_q;

endmodule

[rtl/lottery_scheduler_top.sv]
// Top level of the lottery scheduler: configuration register, sequencer and
// datapath. Depends on lotsch_pkg, lotsch_seq and lotsch_dp.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  command  | start, busy               | op_i, task_index_i, ticket_count_i,
//           |                           | random_value_i
//  result   | done_o (one-cycle strobe) | winner_id_o, slot_start_o, no_tickets_o
//  config   | cfg_we_i                  | cfg_wdata_i (task_count)
//
// A load is taken while idle and busy stays low. A draw keeps busy high through
// its steps: one step to clear, a sum over the first N table entries at one read
// a cycle (N the active task count), one zero check, 31 bit-serial remainder
// steps, one step to clear the walk, the walk and one step to grant.
// done_o rises in the cycle in which busy falls. A zero total skips remainder
// and walk.
// Reset clears the ticket table at once through per-entry valid bits.
// The receiver cannot stall: each result shows for one cycle only.
module lottery_scheduler_top #(
  parameter int unsigned MAX_TASK_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [lotsch_pkg::IDX_W-1:0]  task_index_i,
  input  logic [lotsch_pkg::TIX_W-1:0]  ticket_count_i,
  input  logic [lotsch_pkg::RND_W-1:0]  random_value_i,
  input  logic                          cfg_we_i,
  input  logic [lotsch_pkg::CNT_W-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic [lotsch_pkg::WIN_W-1:0]  winner_id_o,
  output logic [lotsch_pkg::SLOT_W-1:0] slot_start_o,
  output logic                          no_tickets_o
);

  logic [lotsch_pkg::CNT_W-1:0] task_count_q;
  lotsch_pkg::uc_word_t         word;
  lotsch_pkg::dp_status_t       status;
  logic                         seq_busy;
  logic                         accept;

  // Hold the active task count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= lotsch_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      task_count_q <= cfg_wdata_i;
    end
  end

  assign accept = start && !seq_busy;
  assign busy   = seq_busy;

  lotsch_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .word_o   (word),
    .busy_o   (seq_busy)
  );

  lotsch_dp #(
    .MAX_TASK_COUNT (MAX_TASK_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_i         (word),
    .accept_i       (accept),
    .op_i           (op_i),
    .task_index_i   (task_index_i),
    .ticket_count_i (ticket_count_i),
    .random_value_i (random_value_i),
    .task_count_i   (task_count_q),
    .status_o       (status),
    .done_o         (done_o),
    .winner_id_o    (winner_id_o),
    .slot_start_o   (slot_start_o),
    .no_tickets_o   (no_tickets_o)
  );

endmodule

[rtl/lotsch_chk.sv]
// Port-level checker of the lottery scheduler, bound to the top level.
// Depends on lotsch_pkg and lottery_scheduler_top.
module lotsch_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [lotsch_pkg::WIN_W-1:0]  winner_id_o,
  input logic [lotsch_pkg::SLOT_W-1:0] slot_start_o,
  input logic                          no_tickets_o
);

  // An empty draw reports no winner and slot zero
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && no_tickets_o |-> (winner_id_o == '0) && (slot_start_o == '0))
    else $error("empty draw carries a winner or slot");

  // A draw with tickets always grants a task
  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !no_tickets_o |-> (winner_id_o != '0))
    else $error("draw with tickets granted no task");

  // The block is free again when a result shows
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Busy rises only after an accepted command
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // Results are single strobes
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind lottery_scheduler_top lotsch_chk u_lotsch_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .winner_id_o  (winner_id_o),
  .slot_start_o (slot_start_o),
  .no_tickets_o (no_tickets_o)
);

[test/testbench.sv]
// Self-checking testbench for lottery_scheduler_top: directed rows, then random phases.
// Predicts each draw from its own ticket table and slot count; needs rtl/lotsch_pkg.sv.
`timescale 1ns / 100ps

module testbench;

  localparam int TBL_DEPTH       = 16;
  localparam int NUM_DIR         = 28;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 75;

  typedef enum logic { OP_LOAD = 1'b0, OP_DRAW = 1'b1 } op_e;
  typedef enum logic { ROW_CFG = 1'b0, ROW_ITEM = 1'b1 } row_kind_e;

  typedef struct packed {
    logic [lotsch_pkg::WIN_W-1:0]  winner;
    logic [lotsch_pkg::SLOT_W-1:0] slot;
    logic                          no_tix;
  } grant_t;

  typedef struct packed {
    row_kind_e                    kind;
    op_e                          op;
    logic [lotsch_pkg::IDX_W-1:0] idx;
    logic [lotsch_pkg::TIX_W-1:0] tix;
    logic [lotsch_pkg::RND_W-1:0] rnd;
    logic [lotsch_pkg::CNT_W-1:0] cfg;
    logic                         pin;   // expected grant typed in below
    grant_t                       want;
  } stim_row_t;

  // Clock and stimulus signals, all known from time zero
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          start          = 1'b0;
  logic                          busy;
  logic                          op_i           = 1'b0;
  logic [lotsch_pkg::IDX_W-1:0]  task_index_i   = '0;
  logic [lotsch_pkg::TIX_W-1:0]  ticket_count_i = '0;
  logic [lotsch_pkg::RND_W-1:0]  random_value_i = '0;
  logic                          cfg_we_i       = 1'b0;
  logic [lotsch_pkg::CNT_W-1:0]  cfg_wdata_i    = '0;
  logic                          done_o;
  logic [lotsch_pkg::WIN_W-1:0]  winner_id_o;
  logic [lotsch_pkg::SLOT_W-1:0] slot_start_o;
  logic                          no_tickets_o;

  // Typed-in expectation travelling with the current transaction
  logic   pinned_en    = 1'b0;
  grant_t pinned_grant = '0;

  // Predictor state
  logic [lotsch_pkg::TIX_W-1:0]  tix_tbl [TBL_DEPTH] = '{default: '0};
  logic [lotsch_pkg::SLOT_W-1:0] slot_ctr = '0;
  logic [lotsch_pkg::CNT_W-1:0]  act_cnt  = 5'd1;
  grant_t                        grant_q [$];
  grant_t                        next_grant;
  grant_t                        oldest_grant;

  int err_cnt   = 0;
  int n_loads   = 0;
  int n_draws   = 0;
  int n_empty   = 0;
  int n_cfg     = 0;

  stim_row_t                    dir_tbl [NUM_DIR];
  logic [lotsch_pkg::CNT_W-1:0] cfg_seq [7] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8};

  lottery_scheduler_top #(
    .MAX_TASK_COUNT(TBL_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .task_index_i  (task_index_i),
    .ticket_count_i(ticket_count_i),
    .random_value_i(random_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .winner_id_o   (winner_id_o),
    .slot_start_o  (slot_start_o),
    .no_tickets_o  (no_tickets_o)
  );

  always #6 clk_i = ~clk_i;

  // Work out the grant of a draw from the current table, task count and slot
  function automatic grant_t predict_grant(input logic [lotsch_pkg::RND_W-1:0] rnd);
    int unsigned active;
    int unsigned total;
    int unsigned winning;
    int unsigned running;
    grant_t      g;
    active = (act_cnt > TBL_DEPTH) ? TBL_DEPTH : act_cnt;
    total  = 0;
    for (int i = 0; i < active; i++) total += tix_tbl[i];
    g = '{winner: '0, slot: '0, no_tix: 1'b1};
    if (total != 0) begin
      winning  = rnd % total;
      running  = 0;
      g.no_tix = 1'b0;
      g.slot   = slot_ctr;
      for (int i = 0; i < active; i++) begin
        running += tix_tbl[i];
        if (winning < running && g.winner == 0) g.winner = lotsch_pkg::WIN_W'(i + 1);
      end
    end
    return g;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Directed row builders
  function automatic stim_row_t cfg_row(input logic [4:0] v);
    return '{kind: ROW_CFG, op: OP_LOAD, idx: '0, tix: '0, rnd: '0, cfg: v, pin: 1'b0,
             want: '0};
  endfunction

  function automatic stim_row_t load_row(input logic [3:0] idx, input logic [7:0] tix);
    return '{kind: ROW_ITEM, op: OP_LOAD, idx: idx, tix: tix, rnd: '0, cfg: '0, pin: 1'b0,
             want: '0};
  endfunction

  function automatic stim_row_t draw_row(input logic [30:0] rnd);
    return '{kind: ROW_ITEM, op: OP_DRAW, idx: '0, tix: '0, rnd: rnd, cfg: '0, pin: 1'b0,
             want: '0};
  endfunction

  function automatic stim_row_t draw_pin(input logic [30:0] rnd, input logic [4:0] w,
                                         input logic [15:0] s, input logic nt);
    return '{kind: ROW_ITEM, op: OP_DRAW, idx: '0, tix: '0, rnd: rnd, cfg: '0, pin: 1'b1,
             want: '{winner: w, slot: s, no_tix: nt}};
  endfunction

  // Check results and track accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, expected none, actual winner_id %0d",
                   $time, winner_id_o);
        end else begin
          oldest_grant = grant_q.pop_front();
          check_field("winner_id", oldest_grant.winner, winner_id_o);
          check_field("slot_start", oldest_grant.slot, slot_start_o);
          check_field("no_tickets", oldest_grant.no_tix, no_tickets_o);
          if (oldest_grant.no_tix) n_empty++;
        end
      end
      if (cfg_we_i) act_cnt = cfg_wdata_i;
      if (start && !busy) begin
        if (op_i == OP_DRAW) begin
          next_grant = predict_grant(random_value_i);
          if (!next_grant.no_tix) slot_ctr = slot_ctr + 1'b1;
          grant_q.push_back(pinned_en ? pinned_grant : next_grant);
          n_draws++;
        end else begin
          tix_tbl[task_index_i] = ticket_count_i;
          n_loads++;
        end
      end
    end
  end

  // Hold the command until the block takes it
  task automatic send_item(input op_e op, input logic [3:0] idx, input logic [7:0] tix,
                           input logic [30:0] rnd, input logic pin, input grant_t want);
    start          <= 1'b1;
    op_i           <= op;
    task_index_i   <= idx;
    ticket_count_i <= tix;
    random_value_i <= rnd;
    pinned_en      <= pin;
    pinned_grant   <= want;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a random burst now and then
  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Drain every outstanding result, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (grant_q.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [4:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    op_e         r_op;
    logic [3:0]  r_idx;
    logic [7:0]  r_tix;
    logic [30:0] r_rnd;

    // Empty table, one entry, top index, saturated and zero task counts
    dir_tbl = '{
      draw_pin(31'd0, 5'd0, 16'd0, 1'b1),
      draw_pin(31'h7FFF_FFFF, 5'd0, 16'd0, 1'b1),
      load_row(4'd0, 8'd255),
      draw_pin(31'h7FFF_FFFF, 5'd1, 16'd0, 1'b0),
      draw_pin(31'd0, 5'd1, 16'd1, 1'b0),
      load_row(4'd15, 8'd1),
      load_row(4'd0, 8'd0),
      draw_pin(31'd12345, 5'd0, 16'd0, 1'b1),
      cfg_row(5'd16),
      draw_pin(31'h7FFF_FFFF, 5'd16, 16'd2, 1'b0),
      cfg_row(5'd31),
      draw_row(31'd0),
      cfg_row(5'd0),
      draw_pin(31'h7FFF_FFFF, 5'd0, 16'd0, 1'b1),
      cfg_row(5'd5),
      load_row(4'd1, 8'd3),
      load_row(4'd2, 8'd0),
      load_row(4'd3, 8'd200),
      load_row(4'd4, 8'd255),
      draw_row(31'd0),
      draw_row(31'd2),
      draw_row(31'd3),
      draw_row(31'd202),
      draw_row(31'd203),
      draw_row(31'd457),
      draw_row(31'h7FFF_FFFF),
      cfg_row(5'd17),
      draw_row(31'd458)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(dir_tbl[i].cfg);
      end else begin
        send_item(dir_tbl[i].op, dir_tbl[i].idx, dir_tbl[i].tix, dir_tbl[i].rnd,
                  dir_tbl[i].pin, dir_tbl[i].want);
        maybe_gap(1'b1);
      end
    end

    // Random phases, each under its own task count; no idling in the last one
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_cfg(ph < 7 ? cfg_seq[ph] : 5'($urandom_range(0, 31)));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r_op  = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_DRAW;
        r_idx = 4'($urandom);
        case ($urandom_range(0, 9))
          0:       r_tix = 8'd0;
          1:       r_tix = 8'hFF;
          default: r_tix = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       r_rnd = '0;
          1:       r_rnd = '1;
          2:       r_rnd = 31'($urandom_range(0, 600));
          default: r_rnd = 31'($urandom);
        endcase
        send_item(r_op, r_idx, r_tix, r_rnd, 1'b0, '0);
        maybe_gap(ph != NUM_PHASES - 1);
      end
    end

    // Drain and let any late strobe show up
    wait_idle();
    repeat (2 * TBL_DEPTH + 40) @(posedge clk_i);

    $display("Covered %0d loads and %0d draws (%0d with an empty ticket total)",
             n_loads, n_draws, n_empty);
    $display("over %0d task-count writes, with random sender gaps", n_cfg);
    if (err_cnt == 0) begin
      $display("lottery_scheduler_top test passed");
    end else begin
      $display("lottery_scheduler_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("lottery_scheduler_top test failed");
    $finish;
  end

endmodule
